@@ rtl/ropsq_pkg.sv @@
// Package for the reverse-osmosis pump sequencer: widths, codes, the request,
// stage and result types, and the reciprocal constants for the seconds divide.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package ropsq_pkg;

   // Millisecond clock width and field widths.
   localparam int CLOCK_BITS = 32;
   localparam int OP_W       = 3;
   localparam int CHOICE_W   = 2;
   localparam int MODE_W     = 2;
   localparam int ERR_W      = 3;
   localparam int ACT_W      = 4;
   localparam int SW_W       = 2;
   localparam int COUNT_W    = 16;
   localparam int SECONDS_W  = 23;
   localparam int NUM_MODES  = 3;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
   localparam logic [OP_W-1:0] OP_MODE  = 3'd1;
   localparam logic [OP_W-1:0] OP_START = 3'd2;
   localparam logic [OP_W-1:0] OP_LPS   = 3'd3;
   localparam logic [OP_W-1:0] OP_HPS   = 3'd4;

   // Mode select choice that means nothing.
   localparam logic [CHOICE_W-1:0] CHOICE_BAD = 2'd3;

   // Mode codes.
   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAKE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RINSE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_EXPEL = 2'd3;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
   localparam logic [ERR_W-1:0] ERR_LOW     = 3'd1;
   localparam logic [ERR_W-1:0] ERR_HIGH    = 3'd2;
   localparam logic [ERR_W-1:0] ERR_FEED_ON = 3'd3;
   localparam logic [ERR_W-1:0] ERR_PRES_ON = 3'd4;
   localparam logic [ERR_W-1:0] ERR_LPS_ON  = 3'd5;
   localparam logic [ERR_W-1:0] ERR_HPS_ON  = 3'd6;

   // Actuator and switch bit positions.
   localparam int ACT_FEED  = 0;
   localparam int ACT_PRES  = 1;
   localparam int ACT_SALT  = 2;
   localparam int ACT_FRESH = 3;
   localparam int SW_LPS    = 0;
   localparam int SW_HPS    = 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Dividing by 1000: drop three bits, then multiply by a rounded-up
   // reciprocal of 125. With SHIFT = CLOCK_BITS + 4 the error term stays
   // small enough that the quotient is exact for every clock difference.
   localparam int MS_PER_SECOND = 1000;
   localparam int PRE_SHIFT     = 3;
   localparam int ODD_DIV       = MS_PER_SECOND >> PRE_SHIFT;
   localparam int SHIFT         = CLOCK_BITS + 4;
   localparam int Y_W           = CLOCK_BITS - PRE_SHIFT;
   localparam int RECIP_W       = CLOCK_BITS - 2;
   localparam int PROD_W        = Y_W + RECIP_W;
   localparam int QUO_W         = PROD_W - SHIFT;
   localparam logic [SHIFT:0] POW_SHIFT = {1'b1, {SHIFT{1'b0}}};
   localparam logic [SHIFT:0] RECIP_WIDE =
      (POW_SHIFT + (SHIFT+1)'(ODD_DIV - 1)) / (SHIFT+1)'(ODD_DIV);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [CHOICE_W-1:0] mode_choice;
      logic                switch_level;
   } req_type;

   // State snapshot after one request, before the seconds divide.
   typedef struct packed {
      logic [ACT_W-1:0]      act;
      logic [MODE_W-1:0]     mode;
      logic [ERR_W-1:0]      err;
      logic [COUNT_W-1:0]    count;
      logic [CLOCK_BITS-1:0] span;
   } stat_type;

   typedef struct packed {
      logic                 feeder_pump_on;
      logic                 pressure_pump_on;
      logic                 salt_valve_open;
      logic                 fresh_valve_open;
      logic [MODE_W-1:0]    current_mode;
      logic [ERR_W-1:0]     error_code;
      logic [COUNT_W-1:0]   run_count;
      logic [SECONDS_W-1:0] run_seconds;
   } rsp_type;

endpackage

@@ rtl/ropsq_req_if.sv @@
// Request channel of the pump sequencer: valid/ready handshake and the event.
// Depends on ropsq_pkg.
`timescale 1ns / 1ps

interface ropsq_req_if import ropsq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [CHOICE_W-1:0] mode_choice;
   logic                switch_level;

   modport source (output valid, operation, mode_choice, switch_level, input ready);
   modport sink   (input valid, operation, mode_choice, switch_level, output ready);
endinterface

@@ rtl/ropsq_rsp_if.sv @@
// Result channel of the pump sequencer: valid/ready handshake and the status.
// Depends on ropsq_pkg.
`timescale 1ns / 1ps

interface ropsq_rsp_if import ropsq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 feeder_pump_on;
   logic                 pressure_pump_on;
   logic                 salt_valve_open;
   logic                 fresh_valve_open;
   logic [MODE_W-1:0]    current_mode;
   logic [ERR_W-1:0]     error_code;
   logic [COUNT_W-1:0]   run_count;
   logic [SECONDS_W-1:0] run_seconds;

   modport source (output valid, feeder_pump_on, pressure_pump_on, salt_valve_open,
                   fresh_valve_open, current_mode, error_code, run_count, run_seconds,
                   input ready);
   modport sink   (input valid, feeder_pump_on, pressure_pump_on, salt_valve_open,
                   fresh_valve_open, current_mode, error_code, run_count, run_seconds,
                   output ready);
endinterface

@@ rtl/ropsq_core.sv @@
// Interlock state of the pump sequencer: mode, actuators, switches, error,
// millisecond clock and the per-mode run records. Depends on ropsq_pkg.
`timescale 1ns / 1ps

module ropsq_core import ropsq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     commit,
   input  req_type  item,
   output stat_type stat
);

   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [ACT_W-1:0]      act_ff, act_in;
   logic [SW_W-1:0]       sw_ff, sw_in;
   logic [ERR_W-1:0]      err_ff, err_in;
   logic [CLOCK_BITS-1:0] clk_ff, clk_in;
   logic [COUNT_W-1:0]    cnt_ff   [NUM_MODES];
   logic [COUNT_W-1:0]    cnt_in   [NUM_MODES];
   logic [CLOCK_BITS-1:0] start_ff [NUM_MODES];
   logic [CLOCK_BITS-1:0] start_in [NUM_MODES];
   logic [CLOCK_BITS-1:0] stop_ff  [NUM_MODES];
   logic [CLOCK_BITS-1:0] stop_in  [NUM_MODES];

   logic                  running;
   logic                  halt;
   logic                  launch;
   logic [1:0]            slot_cur;
   logic [1:0]            slot_next;
   logic [COUNT_W-1:0]    cnt_sel;
   logic [CLOCK_BITS-1:0] start_sel;
   logic [CLOCK_BITS-1:0] stop_sel;

   assign running  = act_ff[ACT_FEED];
   assign slot_cur = mode_ff - 2'd1;

   always_comb begin
      mode_in = mode_ff;
      act_in  = act_ff;
      sw_in   = sw_ff;
      err_in  = err_ff;
      clk_in  = clk_ff;
      halt    = 1'b0;
      launch  = 1'b0;
      case (item.operation)
         OP_TICK: begin
            clk_in = clk_ff + CLOCK_BITS'(1);
         end
         OP_MODE: begin
            if (item.mode_choice != CHOICE_BAD) begin
               halt    = running;
               err_in  = ERR_NONE;
               mode_in = item.mode_choice + 2'd1;
            end
         end
         OP_START: begin
            if (mode_ff != MODE_NONE) begin
               if (!item.switch_level) begin
                  halt = 1'b1;
               end else if (err_ff == ERR_NONE) begin
                  if (act_ff[ACT_FEED]) begin
                     halt   = 1'b1;
                     err_in = ERR_FEED_ON;
                  end else if (act_ff[ACT_PRES]) begin
                     err_in = ERR_PRES_ON;
                  end else if (sw_ff[SW_LPS]) begin
                     err_in = ERR_LPS_ON;
                  end else if (sw_ff[SW_HPS]) begin
                     err_in = ERR_HPS_ON;
                  end else begin
                     launch = 1'b1;
                  end
               end
            end
         end
         OP_LPS: begin
            sw_in[SW_LPS] = item.switch_level;
            if (mode_ff != MODE_EXPEL && running) begin
               if (item.switch_level) begin
                  act_in[ACT_PRES] = 1'b1;
               end else begin
                  halt   = 1'b1;
                  err_in = ERR_LOW;
               end
            end
         end
         OP_HPS: begin
            sw_in[SW_HPS] = item.switch_level;
            if (running && item.switch_level) begin
               halt   = 1'b1;
               err_in = ERR_HIGH;
            end
         end
         default: begin
         end
      endcase
      if (halt) begin
         act_in = '0;
      end
      if (launch) begin
         act_in = '0;
         act_in[ACT_FEED] = 1'b1;
         if (mode_ff == MODE_MAKE) begin
            act_in[ACT_SALT] = 1'b1;
         end else begin
            act_in[ACT_FRESH] = 1'b1;
         end
      end
   end

   // One lane per mode; only the lane of the current mode is written.
   for (genvar i = 0; i < NUM_MODES; i++) begin : g_lane
      logic hit;
      assign hit = (mode_ff != MODE_NONE) && (slot_cur == 2'(i));

      always_comb begin
         cnt_in[i]   = cnt_ff[i];
         start_in[i] = start_ff[i];
         stop_in[i]  = stop_ff[i];
         if (hit && launch) begin
            start_in[i] = clk_ff;
            if (cnt_ff[i] != COUNT_MAX) begin
               cnt_in[i] = cnt_ff[i] + COUNT_W'(1);
            end
         end
         if (hit && halt) begin
            stop_in[i] = clk_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff[i]   <= '0;
            start_ff[i] <= '0;
            stop_ff[i]  <= '0;
         end else if (commit) begin
            cnt_ff[i]   <= cnt_in[i];
            start_ff[i] <= start_in[i];
            stop_ff[i]  <= stop_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
         act_ff  <= '0;
         sw_ff   <= '0;
         err_ff  <= ERR_NONE;
         clk_ff  <= '0;
      end else if (commit) begin
         mode_ff <= mode_in;
         act_ff  <= act_in;
         sw_ff   <= sw_in;
         err_ff  <= err_in;
         clk_ff  <= clk_in;
      end
   end

   // Report on the record of the mode that holds after this request.
   assign slot_next = mode_in - 2'd1;

   always_comb begin
      cnt_sel   = '0;
      start_sel = '0;
      stop_sel  = '0;
      for (int i = 0; i < NUM_MODES; i++) begin
         if (mode_in != MODE_NONE && slot_next == 2'(i)) begin
            cnt_sel   = cnt_in[i];
            start_sel = start_in[i];
            stop_sel  = stop_in[i];
         end
      end
   end

   always_comb begin
      stat.act   = act_in;
      stat.mode  = mode_in;
      stat.err   = err_in;
      stat.count = cnt_sel;
      stat.span  = '0;
      if (mode_in != MODE_NONE) begin
         if (act_in[ACT_FEED]) begin
            stat.span = clk_in - start_sel;
         end else if (cnt_sel != '0) begin
            stat.span = stop_sel - start_sel;
         end
      end
   end

endmodule

@@ rtl/ropsq_sec.sv @@
// Milliseconds-to-seconds conversion and result formatting for the pump
// sequencer; divides by 1000 with a reciprocal multiply. Depends on ropsq_pkg.
`timescale 1ns / 1ps

module ropsq_sec import ropsq_pkg::*; (
   input  stat_type stat,
   output rsp_type  result
);

   logic [Y_W-1:0]    scaled;
   logic [PROD_W-1:0] product;
   logic [QUO_W-1:0]  quotient;

   assign scaled   = stat.span[CLOCK_BITS-1:PRE_SHIFT];
   assign product  = PROD_W'(scaled) * PROD_W'(RECIP);
   assign quotient = product[PROD_W-1:SHIFT];

   always_comb begin
      result.feeder_pump_on   = stat.act[ACT_FEED];
      result.pressure_pump_on = stat.act[ACT_PRES];
      result.salt_valve_open  = stat.act[ACT_SALT];
      result.fresh_valve_open = stat.act[ACT_FRESH];
      result.current_mode     = stat.mode;
      result.error_code       = stat.err;
      result.run_count        = stat.count;
      result.run_seconds      = SECONDS_W'(quotient);
   end

endmodule

@@ rtl/reverse_osmosis_pump_sequencer_unit.sv @@
// Reverse-osmosis pump sequencer, top level.
// The request is registered in the input register when accepted, the state updates and
// the status is registered as the request leaves it, and the seconds conversion loads
// the result register. Throughput: one request per cycle while results are taken;
// the reciprocal multiply sets the cycle time.
// Reset is synchronous and active high; it clears all state and run records,
// and the block accepts requests in the first cycle after reset.
`timescale 1ns / 1ps

module reverse_osmosis_pump_sequencer_unit import ropsq_pkg::*; (
   input logic         clock,
   input logic         reset,
   ropsq_req_if.sink   req_ch,
   ropsq_rsp_if.source rsp_ch
);

   // Three-stage elastic pipeline. Each stage loads when it is empty or when
   // the stage after it moves on, so a waiting result never blocks new
   // requests while there is a free stage behind it.
   req_type  in_ff;
   logic     in_valid_ff;
   stat_type mid_ff;
   logic     mid_valid_ff;
   rsp_type  rsp_ff;
   logic     rsp_valid_ff;

   logic     out_ready;
   logic     mid_ready;
   logic     in_ready;
   logic     commit;
   stat_type stat;
   rsp_type  result;
   req_type  req_item;

   assign out_ready = !rsp_valid_ff || rsp_ch.ready;
   assign mid_ready = !mid_valid_ff || out_ready;
   assign in_ready  = !in_valid_ff || mid_ready;

   // The interlock state advances exactly once per request, when the request
   // leaves the input register.
   assign commit = in_valid_ff && mid_ready;

   assign req_ch.ready          = in_ready;
   assign req_item.operation    = req_ch.operation;
   assign req_item.mode_choice  = req_ch.mode_choice;
   assign req_item.switch_level = req_ch.switch_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_ch.valid) begin
         in_ff <= req_item;
      end
   end

   ropsq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .commit (commit),
      .item   (in_ff),
      .stat   (stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (mid_ready) begin
         mid_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         mid_ff <= stat;
      end
   end

   ropsq_sec u_sec (
      .stat   (mid_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && mid_valid_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.feeder_pump_on   = rsp_ff.feeder_pump_on;
   assign rsp_ch.pressure_pump_on = rsp_ff.pressure_pump_on;
   assign rsp_ch.salt_valve_open  = rsp_ff.salt_valve_open;
   assign rsp_ch.fresh_valve_open = rsp_ff.fresh_valve_open;
   assign rsp_ch.current_mode     = rsp_ff.current_mode;
   assign rsp_ch.error_code       = rsp_ff.error_code;
   assign rsp_ch.run_count        = rsp_ff.run_count;
   assign rsp_ch.run_seconds      = rsp_ff.run_seconds;

   // The pressure pump only runs together with the feeder pump.
   a_pres_needs_feed : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.pressure_pump_on || rsp_ff.feeder_pump_on))
      else $error("pressure pump on without feeder pump");

   // A latched error leaves every actuator off.
   a_error_stops_all : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.error_code != ERR_NONE) |->
         (!rsp_ff.feeder_pump_on && !rsp_ff.pressure_pump_on &&
          !rsp_ff.salt_valve_open && !rsp_ff.fresh_valve_open))
      else $error("actuator on with an error latched");

   // With no mode set there is no run record to report.
   a_no_mode_no_record : assert property (@(posedge clock) disable iff (reset)
      (mid_valid_ff && mid_ff.mode == MODE_NONE) |->
         (mid_ff.count == '0 && mid_ff.span == '0 && mid_ff.act == '0))
      else $error("run record reported with no mode set");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the reverse-osmosis pump sequencer unit.
// It uses ropsq_pkg, the two channel interfaces and the unit's top level.
// A small status book in the bench predicts every status and checks it.
`timescale 1ns / 1ps

module tb import ropsq_pkg::*; ();

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 3;
   // Extra wait after the last status has arrived, to let the unit drain.
   localparam int DRAIN_CYCLES   = 12;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_ITEMS    = 100;
   localparam int TIMEOUT_CYCLES = 2_000_000;
   localparam int MAX_REPORTS    = 30;

   // Mode select choices and switch levels as the request encodes them.
   localparam logic [CHOICE_W-1:0] CHOICE_MAKE  = 2'd0;
   localparam logic [CHOICE_W-1:0] CHOICE_RINSE = 2'd1;
   localparam logic [CHOICE_W-1:0] CHOICE_EXPEL = 2'd2;
   localparam logic LEVEL_OPEN   = 1'b0;
   localparam logic LEVEL_CLOSED = 1'b1;
   // Operation codes that the unit must ignore.
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   // Status book: keeps its own copy of the plant state, works out the status
   // that each accepted request must produce and checks the statuses in order.
   class plant_status_book;
      logic [MODE_W-1:0]     mode;
      logic [ACT_W-1:0]      act;
      logic [SW_W-1:0]       sw;
      logic [ERR_W-1:0]      err;
      logic [CLOCK_BITS-1:0] ms;
      logic [COUNT_W-1:0]    runs  [NUM_MODES];
      logic [CLOCK_BITS-1:0] t_on  [NUM_MODES];
      logic [CLOCK_BITS-1:0] t_off [NUM_MODES];
      rsp_type               status_due [$];
      int unsigned           requests_logged;
      int unsigned           statuses_matched;
      int unsigned           mismatches;
      int unsigned           runs_started;
      int unsigned           longest_secs;

      function new();
         mode = MODE_NONE;
         act  = '0;
         sw   = '0;
         err  = ERR_NONE;
         ms   = '0;
         foreach (runs[i]) begin
            runs[i]  = '0;
            t_on[i]  = '0;
            t_off[i] = '0;
         end
         requests_logged  = 0;
         statuses_matched = 0;
         mismatches       = 0;
         runs_started     = 0;
         longest_secs     = 0;
      endfunction

      function int slot();
         return int'(mode) - 1;
      endfunction

      function void halt();
         act = '0;
         if (mode != MODE_NONE) t_off[slot()] = ms;
      endfunction

      function void trip(logic [ERR_W-1:0] code);
         if (act[ACT_FEED]) halt();
         err = code;
      endfunction

      function void try_run();
         if (mode == MODE_NONE || err != ERR_NONE) return;
         if (act[ACT_FEED]) trip(ERR_FEED_ON);
         else if (act[ACT_PRES]) trip(ERR_PRES_ON);
         else if (sw[SW_LPS]) trip(ERR_LPS_ON);
         else if (sw[SW_HPS]) trip(ERR_HPS_ON);
         else begin
            act = '0;
            act[ACT_FEED] = 1'b1;
            if (mode == MODE_MAKE) act[ACT_SALT] = 1'b1;
            else act[ACT_FRESH] = 1'b1;
            t_on[slot()] = ms;
            if (runs[slot()] != COUNT_MAX) runs[slot()] = runs[slot()] + 1'b1;
            runs_started++;
         end
      endfunction

      function void log_request(req_type r);
         rsp_type               s;
         logic [CLOCK_BITS-1:0] span;
         requests_logged++;
         case (r.operation)
            OP_TICK:  ms = ms + 1'b1;
            OP_MODE: begin
               if (r.mode_choice != CHOICE_BAD) begin
                  if (act[ACT_FEED]) halt();
                  err  = ERR_NONE;
                  mode = MODE_W'(r.mode_choice + 1);
               end
            end
            OP_START: begin
               if (mode != MODE_NONE) begin
                  if (r.switch_level) try_run();
                  else halt();
               end
            end
            OP_LPS: begin
               sw[SW_LPS] = r.switch_level;
               if (mode != MODE_EXPEL && act[ACT_FEED]) begin
                  if (r.switch_level) act[ACT_PRES] = 1'b1;
                  else trip(ERR_LOW);
               end
            end
            OP_HPS: begin
               sw[SW_HPS] = r.switch_level;
               if (act[ACT_FEED] && r.switch_level) trip(ERR_HIGH);
            end
            default: ;
         endcase
         s = '0;
         s.feeder_pump_on   = act[ACT_FEED];
         s.pressure_pump_on = act[ACT_PRES];
         s.salt_valve_open  = act[ACT_SALT];
         s.fresh_valve_open = act[ACT_FRESH];
         s.current_mode     = mode;
         s.error_code       = err;
         if (mode != MODE_NONE) begin
            span = '0;
            s.run_count = runs[slot()];
            if (act[ACT_FEED]) span = ms - t_on[slot()];
            else if (runs[slot()] != '0) span = t_off[slot()] - t_on[slot()];
            s.run_seconds = SECONDS_W'(span / CLOCK_BITS'(MS_PER_SECOND));
         end
         status_due.push_back(s);
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            if (mismatches < MAX_REPORTS)
               $error("status %0d: %s expected %0d, got %0d",
                      statuses_matched, field, want, got);
            mismatches++;
         end
      endfunction

      function void match_status(rsp_type got);
         rsp_type want;
         if (status_due.size() == 0) begin
            if (mismatches < MAX_REPORTS) $error("status arrived with no request outstanding");
            mismatches++;
            return;
         end
         want = status_due.pop_front();
         compare_field("feeder_pump_on", want.feeder_pump_on, got.feeder_pump_on);
         compare_field("pressure_pump_on", want.pressure_pump_on, got.pressure_pump_on);
         compare_field("salt_valve_open", want.salt_valve_open, got.salt_valve_open);
         compare_field("fresh_valve_open", want.fresh_valve_open, got.fresh_valve_open);
         compare_field("current_mode", want.current_mode, got.current_mode);
         compare_field("error_code", want.error_code, got.error_code);
         compare_field("run_count", want.run_count, got.run_count);
         compare_field("run_seconds", want.run_seconds, got.run_seconds);
         if (want.run_seconds > longest_secs) longest_secs = want.run_seconds;
         statuses_matched++;
      endfunction

      function int unsigned pending();
         return status_due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   ropsq_req_if req_ch ();
   ropsq_rsp_if rsp_ch ();

   reverse_osmosis_pump_sequencer_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   plant_status_book book = new();

   // Idle percentages of the current phase; the sender reads its own when it offers a
   // request and the receiver reads its own on every cycle.
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned requests_sent = 0;
   logic        hold_off;
   event        hold_go;

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // Watchdog. The run normally ends far earlier; this only catches a hang.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $error("timeout with %0d statuses still outstanding", book.pending());
      $display("tb: FAIL");
      $finish;
   end

   // Long receiver hold-off. While it lasts the sender keeps offering requests,
   // so the unit's pipeline fills and it has to drop its request ready.
   initial begin
      hold_off = 1'b0;
      forever begin
         @(hold_go);
         hold_off <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_off <= 1'b0;
      end
   end

   // Watcher and receiver. Both handshakes are judged on the values that held
   // just before the rising edge, so the order of processes within the edge
   // does not matter. A request is logged in the book when accepted; a status
   // is checked against the oldest outstanding prediction.
   initial begin
      req_type seen;
      rsp_type got;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && req_ch.valid && req_ch.ready) begin
            seen.operation    = req_ch.operation;
            seen.mode_choice  = req_ch.mode_choice;
            seen.switch_level = req_ch.switch_level;
            book.log_request(seen);
         end
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.feeder_pump_on   = rsp_ch.feeder_pump_on;
            got.pressure_pump_on = rsp_ch.pressure_pump_on;
            got.salt_valve_open  = rsp_ch.salt_valve_open;
            got.fresh_valve_open = rsp_ch.fresh_valve_open;
            got.current_mode     = rsp_ch.current_mode;
            got.error_code       = rsp_ch.error_code;
            got.run_count        = rsp_ch.run_count;
            got.run_seconds      = rsp_ch.run_seconds;
            book.match_status(got);
         end
         if (hold_off) rsp_ch.ready <= 1'b0;
         else rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Offers one request and returns in the cycle after it was accepted. Valid
   // is lowered only when an idle gap is drawn, so back-to-back requests keep
   // it high without a second assignment in the same time step.
   task automatic offer(input logic [OP_W-1:0] op, input logic [CHOICE_W-1:0] choice,
                        input logic level);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= op;
      req_ch.mode_choice  <= choice;
      req_ch.switch_level <= level;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      requests_sent++;
   endtask

   // Millisecond ticks. The unused fields carry random bits, which the unit
   // must ignore for a tick.
   task automatic tick_for(input int unsigned n);
      repeat (n) offer(OP_TICK, CHOICE_W'($urandom), 1'($urandom));
   endtask

   function automatic logic [CHOICE_W-1:0] pick_choice();
      if ($urandom_range(0, 15) == 0) return CHOICE_BAD;
      return CHOICE_W'($urandom_range(0, 2));
   endfunction

   // One plant run as an operator would do it: select a mode, make sure both
   // pressure switches are open, press start, let pressure build and run for a
   // while, then end it one of several ways. Each setup step is sometimes
   // left out, which gives the broken sequences that hit the interlocks.
   task automatic plant_run();
      int unsigned ending;
      if ($urandom_range(0, 9) != 0) offer(OP_MODE, pick_choice(), 1'($urandom));
      if ($urandom_range(0, 9) != 0) offer(OP_LPS, CHOICE_W'($urandom), LEVEL_OPEN);
      if ($urandom_range(0, 9) != 0) offer(OP_HPS, CHOICE_W'($urandom), LEVEL_OPEN);
      tick_for($urandom_range(0, 3));
      if ($urandom_range(0, 9) != 0) offer(OP_START, CHOICE_W'($urandom), LEVEL_CLOSED);
      tick_for($urandom_range(0, 6));
      if ($urandom_range(0, 7) != 0) offer(OP_LPS, CHOICE_W'($urandom), LEVEL_CLOSED);
      tick_for($urandom_range(0, 40));
      ending = $urandom_range(0, 6);
      case (ending)
         0, 1: offer(OP_START, CHOICE_W'($urandom), LEVEL_OPEN);    // normal stop
         2:    offer(OP_LPS, CHOICE_W'($urandom), LEVEL_OPEN);      // pressure lost
         3:    offer(OP_HPS, CHOICE_W'($urandom), LEVEL_CLOSED);    // overpressure
         4:    offer(OP_MODE, pick_choice(), 1'($urandom));         // mode change
         5:    offer(OP_START, CHOICE_W'($urandom), LEVEL_CLOSED);  // start while running
         default: ;                                                 // left running
      endcase
      tick_for($urandom_range(0, 3));
   endtask

   // Fills one idling phase with well-formed runs and some raw noise, which
   // also reaches the unused operation codes and the bad mode choice.
   task automatic random_phase(input int unsigned idle_pct, input int unsigned stall);
      int unsigned phase_end;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      phase_end     = requests_sent + PHASE_ITEMS;
      while (requests_sent < phase_end) begin
         if ($urandom_range(0, 99) < 20)
            offer(OP_W'($urandom_range(0, 7)), CHOICE_W'($urandom), 1'($urandom));
         else
            plant_run();
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.operation    <= OP_TICK;
      req_ch.mode_choice  <= CHOICE_MAKE;
      req_ch.switch_level <= LEVEL_OPEN;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part. With no mode set, start and stop do nothing; a bad
      // mode choice and the unused operations change nothing either.
      offer(OP_START, CHOICE_MAKE, LEVEL_CLOSED);
      offer(OP_START, CHOICE_MAKE, LEVEL_OPEN);
      offer(OP_MODE, CHOICE_BAD, LEVEL_OPEN);
      offer(OP_SPARE_LO, CHOICE_MAKE, LEVEL_OPEN);
      offer(OP_SPARE_HI, CHOICE_BAD, LEVEL_CLOSED);
      offer(OP_TICK, CHOICE_BAD, LEVEL_CLOSED);
      // A normal start in make-water mode, pressure builds, then start is
      // pressed again while running, which latches the feeder-on error.
      offer(OP_MODE, CHOICE_MAKE, LEVEL_OPEN);
      offer(OP_START, CHOICE_MAKE, LEVEL_CLOSED);
      offer(OP_LPS, CHOICE_MAKE, LEVEL_CLOSED);
      offer(OP_TICK, CHOICE_MAKE, LEVEL_OPEN);
      offer(OP_START, CHOICE_MAKE, LEVEL_CLOSED);
      // Start interlocks: low-pressure switch still closed, so both starts trip on it.
      offer(OP_MODE, CHOICE_RINSE, LEVEL_OPEN);
      offer(OP_HPS, CHOICE_RINSE, LEVEL_CLOSED);
      offer(OP_START, CHOICE_RINSE, LEVEL_CLOSED);
      offer(OP_HPS, CHOICE_RINSE, LEVEL_OPEN);
      offer(OP_MODE, CHOICE_RINSE, LEVEL_OPEN);
      offer(OP_START, CHOICE_RINSE, LEVEL_CLOSED);
      // Expel air: start still meets the closed low-pressure switch, so the plant stays off
      // and the switch levels that follow, in both directions, are only recorded.
      offer(OP_MODE, CHOICE_EXPEL, LEVEL_OPEN);
      offer(OP_START, CHOICE_EXPEL, LEVEL_CLOSED);
      offer(OP_LPS, CHOICE_EXPEL, LEVEL_CLOSED);
      offer(OP_LPS, CHOICE_EXPEL, LEVEL_OPEN);
      offer(OP_HPS, CHOICE_EXPEL, LEVEL_CLOSED);
      // Losing pressure while running latches the low-pressure error.
      offer(OP_MODE, CHOICE_MAKE, LEVEL_OPEN);
      offer(OP_HPS, CHOICE_MAKE, LEVEL_OPEN);
      offer(OP_START, CHOICE_MAKE, LEVEL_CLOSED);
      offer(OP_LPS, CHOICE_MAKE, LEVEL_OPEN);

      // One longer rinse run with pressure built, a stop, a few ticks after
      // it and a second stop, so that the run record is reported both while
      // running and after the stop.
      offer(OP_MODE, CHOICE_RINSE, LEVEL_OPEN);
      offer(OP_START, CHOICE_RINSE, LEVEL_CLOSED);
      offer(OP_LPS, CHOICE_RINSE, LEVEL_CLOSED);
      tick_for($urandom_range(120, 200));
      offer(OP_START, CHOICE_RINSE, LEVEL_OPEN);
      tick_for(3);
      offer(OP_START, CHOICE_RINSE, LEVEL_OPEN);

      // Random phases. The first one starts with the long receiver hold-off
      // while the sender offers requests back to back.
      -> hold_go;
      random_phase(0, 0);
      random_phase(52, 0);
      random_phase(0, 52);
      random_phase(24, 24);

      req_ch.valid <= 1'b0;
      stall_pct = 0;
      while (book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d requests sent, %0d statuses checked, %0d mismatches.",
               requests_sent, book.statuses_matched, book.mismatches);
      $display("Summary: %0d plant runs started, longest run seen %0d s.",
               book.runs_started, book.longest_secs);
      if (book.mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
